// ===== sv/lpmr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmr_pkg: shared types and constants of the mailbox ring unit
// Function and status codes, put states, engine states, queue entry.
// ----------------------------------------------------------------------------
package lpmr_pkg;

    localparam int DEF_NUM_BOXES   = 8;
    localparam int DEF_BOX_BYTES   = 1024;
    localparam int DEF_SLACK_BYTES = 256;

    localparam logic [10:0] CAP_RESET  = 11'd1024;
    localparam logic [7:0]  MASK_RESET = 8'd0;

    localparam logic [2:0] REG_CAP_ADDR  = 3'd0;
    localparam logic [2:0] REG_MASK_ADDR = 3'd4;

    localparam logic [2:0] FN_PUT      = 3'd0;
    localparam logic [2:0] FN_PUT_ROOM = 3'd1;
    localparam logic [2:0] FN_GET      = 3'd2;
    localparam logic [2:0] FN_DROP     = 3'd3;
    localparam logic [2:0] FN_CLEAR    = 3'd4;
    localparam logic [2:0] FN_COUNT    = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_REJ   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam logic [15:0] HDR_LEN = 16'd2;

    typedef enum logic [1:0] {
        PS_IDLE = 2'd0,
        PS_HIGH = 2'd1,
        PS_BODY = 2'd2,
        PS_SKIP = 2'd3
    } put_state_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_EXEC,
        BS_WR2,
        BS_HA,
        BS_HB,
        BS_HC,
        BS_GD
    } back_state_t;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] box;
        logic [7:0] data_byte;
        logic       bad;
    } op_entry_t;

endpackage

// ===== sv/lpmr_front.sv =====
// ----------------------------------------------------------------------------
// lpmr_front: input acceptance and classification
// Flags bad boxes and queues transactions for the engine.
// ----------------------------------------------------------------------------
module lpmr_front import lpmr_pkg::*; #(
    parameter int NUM_BOXES = DEF_NUM_BOXES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [2:0] s_func,
    input  logic [2:0] s_box,
    input  logic [7:0] s_data_byte,
    input  logic [7:0] enable_mask,
    output logic       q_valid,
    output op_entry_t  q_entry,
    input  logic       q_pop
);

    op_entry_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    op_entry_t  in_entry;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_entry  = q_reg[rd_ptr_reg];

    always_comb begin
        in_entry.func      = s_func;
        in_entry.box       = s_box;
        in_entry.data_byte = s_data_byte;
        in_entry.bad       = (32'(s_box) >= NUM_BOXES) || !enable_mask[s_box];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

// ===== sv/lpmr_back.sv =====
// ----------------------------------------------------------------------------
// lpmr_back: mailbox engine
// Per-box ring state, message store and result register.
// ----------------------------------------------------------------------------
module lpmr_back import lpmr_pkg::*; #(
    parameter int NUM_BOXES   = DEF_NUM_BOXES,
    parameter int BOX_BYTES   = DEF_BOX_BYTES,
    parameter int SLACK_BYTES = DEF_SLACK_BYTES,
    parameter int AW          = $clog2(BOX_BYTES + SLACK_BYTES)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [AW-1:0] cap_eff,
    input  logic          cfg_clear,
    input  logic          q_valid,
    input  op_entry_t     q_entry,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [1:0]    m_status,
    output logic [7:0]    m_read_byte,
    output logic          m_eom,
    output logic [9:0]    m_count
);

    localparam int REGION = BOX_BYTES + SLACK_BYTES;
    localparam int STORE  = NUM_BOXES * REGION;
    localparam int MW     = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int BW     = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
    localparam int CW     = $clog2(BOX_BYTES / 2 + 1);
    localparam int SW     = ((AW > 16) ? AW : 16) + 1;
    localparam int FREE_RST = (BOX_BYTES < 1024) ? BOX_BYTES : 1024;

    logic [7:0] mem [STORE];
    logic [7:0] rdata_reg;

    logic [AW-1:0] wp_reg   [NUM_BOXES];
    logic [AW-1:0] rp_reg   [NUM_BOXES];
    logic [AW-1:0] free_reg [NUM_BOXES];
    logic [CW-1:0] cnt_reg  [NUM_BOXES];
    logic [15:0]   pbl_reg  [NUM_BOXES];
    logic [15:0]   plen_reg [NUM_BOXES];
    put_state_t    pst_reg  [NUM_BOXES];
    logic [15:0]   gbl_reg  [NUM_BOXES];

    back_state_t st_reg, st_next;
    op_entry_t   op_reg, op_next;
    logic [7:0]  hi_reg, hi_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] gnew_reg, gnew_next;

    logic       ov_reg, ov_next;
    logic [1:0] os_reg, os_next;
    logic [7:0] ob_reg, ob_next;
    logic       oe_reg, oe_next;
    logic [9:0] oc_reg, oc_next;

    logic [BW-1:0] bi;
    logic [AW-1:0] c_wp, c_rp, c_free;
    logic [CW-1:0] c_cnt;
    logic [15:0]   c_pbl, c_plen, c_gbl;
    put_state_t    c_pst;

    logic          upd;
    logic [AW-1:0] n_wp, n_rp, n_free;
    logic [CW-1:0] n_cnt;
    logic [15:0]   n_pbl, n_plen, n_gbl;
    put_state_t    n_pst;

    logic          we;
    logic [AW-1:0] w_off, r_off;
    logic [7:0]    w_data;
    logic          done;
    logic [1:0]    r_status;
    logic [7:0]    r_byte;
    logic          r_eom;
    logic [15:0]   put_len, head_len, gsel, pos;
    logic [AW-1:0] free_rel;
    logic          can_start;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p,
                                              input logic [15:0] l,
                                              input logic [AW-1:0] cap);
        logic [SW-1:0] s;
        s = SW'(p) + SW'(l);
        advance = (s > SW'(cap)) ? '0 : AW'(s);
    endfunction

    function automatic logic fits(input logic [15:0] l, input logic [AW-1:0] fr);
        fits = (l >= HDR_LEN) && (SW'(l) <= SW'(fr)) && (32'(l) <= SLACK_BYTES);
    endfunction

    function automatic logic [MW-1:0] addr(input logic [BW-1:0] b,
                                           input logic [AW-1:0] off);
        addr = MW'(b) * MW'(REGION) + MW'(off);
    endfunction

    assign bi       = BW'(op_reg.box);
    assign c_wp     = wp_reg[bi];
    assign c_rp     = rp_reg[bi];
    assign c_free   = free_reg[bi];
    assign c_cnt    = cnt_reg[bi];
    assign c_pbl    = pbl_reg[bi];
    assign c_plen   = plen_reg[bi];
    assign c_pst    = pst_reg[bi];
    assign c_gbl    = gbl_reg[bi];
    assign put_len  = {c_pbl[7:0], op_reg.data_byte};
    assign head_len = {hi_reg, rdata_reg};
    assign gsel     = ((c_gbl == 16'd0) || (c_gbl > head_len)) ? head_len : c_gbl;
    assign pos      = head_len - gsel;
    assign free_rel = c_free + AW'(head_len);
    assign can_start = !ov_reg || m_tready;

    assign m_tvalid    = ov_reg;
    assign m_status    = os_reg;
    assign m_read_byte = ob_reg;
    assign m_eom       = oe_reg;
    assign m_count     = oc_reg;

    always_comb begin
        st_next = st_reg;  op_next = op_reg;  hi_next = hi_reg;
        len_next = len_reg;  gnew_next = gnew_reg;
        q_pop = 1'b0;
        upd = 1'b0;
        n_wp = c_wp;  n_rp = c_rp;  n_free = c_free;  n_cnt = c_cnt;
        n_pbl = c_pbl;  n_plen = c_plen;  n_pst = c_pst;  n_gbl = c_gbl;
        we = 1'b0;  w_off = c_wp;  w_data = op_reg.data_byte;
        r_off = c_rp;
        done = 1'b0;  r_status = ST_OK;  r_byte = 8'd0;  r_eom = 1'b0;

        case (st_reg)
            BS_IDLE: begin
                if (q_valid && can_start) begin
                    q_pop   = 1'b1;
                    op_next = q_entry;
                    st_next = BS_EXEC;
                end
            end
            BS_EXEC: begin
                if (op_reg.bad) begin
                    done = 1'b1;  r_status = ST_BAD;
                end else begin
                    case (op_reg.func)
                        FN_PUT, FN_PUT_ROOM: begin
                            case (c_pst)
                                PS_IDLE: begin
                                    upd = 1'b1;  n_pbl = {8'd0, op_reg.data_byte};
                                    n_pst = PS_HIGH;  done = 1'b1;
                                end
                                PS_HIGH: begin
                                    len_next = put_len;
                                    if (fits(put_len, c_free)) begin
                                        we = 1'b1;  w_data = c_pbl[7:0];
                                        st_next = BS_WR2;
                                    end else if (op_reg.func == FN_PUT_ROOM &&
                                                 c_cnt != '0) begin
                                        st_next = BS_HA;
                                    end else begin
                                        upd = 1'b1;  done = 1'b1;  r_status = ST_REJ;
                                        if (put_len > HDR_LEN) begin
                                            n_pbl = put_len - HDR_LEN;  n_pst = PS_SKIP;
                                        end else begin
                                            n_pbl = 16'd0;  n_pst = PS_IDLE;  r_eom = 1'b1;
                                        end
                                    end
                                end
                                PS_BODY: begin
                                    we = 1'b1;
                                    w_off = c_wp + AW'(c_plen - c_pbl);
                                    upd = 1'b1;  done = 1'b1;
                                    n_pbl = c_pbl - 16'd1;
                                    if (c_pbl == 16'd1) begin
                                        n_wp = advance(c_wp, c_plen, cap_eff);
                                        n_free = c_free - AW'(c_plen);
                                        n_cnt = c_cnt + 1'b1;
                                        n_pst = PS_IDLE;  r_eom = 1'b1;
                                    end
                                end
                                default: begin
                                    upd = 1'b1;  done = 1'b1;  r_status = ST_REJ;
                                    n_pbl = c_pbl - 16'd1;
                                    if (c_pbl == 16'd1) begin
                                        n_pst = PS_IDLE;  r_eom = 1'b1;
                                    end
                                end
                            endcase
                        end
                        FN_GET, FN_DROP: begin
                            if (c_cnt == '0) begin
                                done = 1'b1;  r_status = ST_EMPTY;
                            end else begin
                                st_next = BS_HA;
                            end
                        end
                        FN_CLEAR: begin
                            upd = 1'b1;  done = 1'b1;
                            n_wp = '0;  n_rp = '0;  n_free = cap_eff;  n_cnt = '0;
                            n_pbl = 16'd0;  n_pst = PS_IDLE;  n_gbl = 16'd0;
                        end
                        FN_COUNT: begin
                            done = 1'b1;
                        end
                        default: begin
                            done = 1'b1;  r_status = ST_REJ;
                        end
                    endcase
                end
            end
            BS_WR2: begin
                // low header byte, then commit an empty-body message at once
                we = 1'b1;  w_off = c_wp + AW'(1);
                upd = 1'b1;  done = 1'b1;
                n_plen = len_reg;
                if (len_reg == HDR_LEN) begin
                    n_wp = advance(c_wp, len_reg, cap_eff);
                    n_free = c_free - AW'(len_reg);
                    n_cnt = c_cnt + 1'b1;
                    n_pbl = 16'd0;  n_pst = PS_IDLE;  r_eom = 1'b1;
                end else begin
                    n_pbl = len_reg - HDR_LEN;  n_pst = PS_BODY;
                end
            end
            BS_HA: begin
                r_off = c_rp;  st_next = BS_HB;
            end
            BS_HB: begin
                hi_next = rdata_reg;  r_off = c_rp + AW'(1);  st_next = BS_HC;
            end
            BS_HC: begin
                if (op_reg.func == FN_GET) begin
                    len_next = head_len;  gnew_next = gsel;
                    r_off = c_rp + AW'(pos);  st_next = BS_GD;
                end else begin
                    upd = 1'b1;
                    n_rp = advance(c_rp, head_len, cap_eff);
                    n_free = free_rel;  n_cnt = c_cnt - 1'b1;  n_gbl = 16'd0;
                    if (op_reg.func == FN_DROP) begin
                        done = 1'b1;  st_next = BS_IDLE;
                    end else if (fits(len_reg, free_rel)) begin
                        we = 1'b1;  w_data = c_pbl[7:0];  st_next = BS_WR2;
                    end else begin
                        done = 1'b1;  r_status = ST_REJ;
                        if (len_reg > HDR_LEN) begin
                            n_pbl = len_reg - HDR_LEN;  n_pst = PS_SKIP;
                        end else begin
                            n_pbl = 16'd0;  n_pst = PS_IDLE;  r_eom = 1'b1;
                        end
                    end
                end
            end
            BS_GD: begin
                upd = 1'b1;  done = 1'b1;  r_byte = rdata_reg;
                n_gbl = gnew_reg - 16'd1;
                if (gnew_reg == 16'd1) begin
                    n_rp = advance(c_rp, len_reg, cap_eff);
                    n_free = c_free + AW'(len_reg);
                    n_cnt = c_cnt - 1'b1;  n_gbl = 16'd0;  r_eom = 1'b1;
                end
            end
            default: begin
                st_next = BS_IDLE;
            end
        endcase

        if (done) begin
            st_next = BS_IDLE;
        end

        ov_next = (ov_reg && !m_tready) || done;
        os_next = os_reg;  ob_next = ob_reg;  oe_next = oe_reg;  oc_next = oc_reg;
        if (done) begin
            os_next = r_status;
            ob_next = r_byte;
            oe_next = r_eom;
            oc_next = op_reg.bad ? 10'd0 : 10'(upd ? n_cnt : c_cnt);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= BS_IDLE;
            ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        hi_reg   <= hi_next;
        len_reg  <= len_next;
        gnew_reg <= gnew_next;
        os_reg   <= os_next;
        ob_reg   <= ob_next;
        oe_reg   <= oe_next;
        oc_reg   <= oc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clear) begin
            for (int i = 0; i < NUM_BOXES; i++) begin
                wp_reg[i]   <= '0;
                rp_reg[i]   <= '0;
                free_reg[i] <= aresetn ? cap_eff : AW'(FREE_RST);
                cnt_reg[i]  <= '0;
                pbl_reg[i]  <= 16'd0;
                plen_reg[i] <= 16'd0;
                pst_reg[i]  <= PS_IDLE;
                gbl_reg[i]  <= 16'd0;
            end
        end else if (upd) begin
            wp_reg[bi]   <= n_wp;
            rp_reg[bi]   <= n_rp;
            free_reg[bi] <= n_free;
            cnt_reg[bi]  <= n_cnt;
            pbl_reg[bi]  <= n_pbl;
            plen_reg[bi] <= n_plen;
            pst_reg[bi]  <= n_pst;
            gbl_reg[bi]  <= n_gbl;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr(bi, w_off)] <= w_data;
        end
        rdata_reg <= mem[addr(bi, r_off)];
    end

endmodule

// ===== sv/length_prefixed_mailbox_ring_unit.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_mailbox_ring_unit: mailbox rings of length-prefixed messages
// Top level with configuration registers, front queue and engine.
// ----------------------------------------------------------------------------
// Each operation is one transaction on s_t*; each returns exactly one result
// transaction on m_t*, in order. Messages carry a two-byte big-endian length
// that counts the header. The engine works on one transaction at a time: a
// put, clear, count or rejected operation completes in the execute state, a
// header-accepting put byte also writes the second header byte, and a drop,
// a get byte or a make-room put first fetch the oldest header through the
// single read port of the message store. A two-entry queue in front takes
// up to two transactions while the engine or the result register is busy.
// Writing box_capacity (APB offset 0x0) clears every box; write the
// registers only while no operation is outstanding. box_enable_mask sits at
// offset 0x4. The store has no reset; only committed bytes are ever read.
// ----------------------------------------------------------------------------
module length_prefixed_mailbox_ring_unit import lpmr_pkg::*; #(
    parameter int NUM_BOXES   = DEF_NUM_BOXES,
    parameter int BOX_BYTES   = DEF_BOX_BYTES,
    parameter int SLACK_BYTES = DEF_SLACK_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // func[2:0], box[5:3], data_byte[13:6], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[1:0], read_byte[9:2], message_count[19:10]
    output logic        m_tlast,   // end_of_message
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(BOX_BYTES + SLACK_BYTES);

    logic [10:0]   cap_reg, cap_next;
    logic [7:0]    mask_reg, mask_next;
    logic          cfg_wr, cfg_clear;
    logic [AW-1:0] cap_eff;
    logic          q_valid, q_pop;
    op_entry_t     q_entry;
    logic [1:0]    r_status;
    logic [7:0]    r_byte;
    logic [9:0]    r_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_clear = cfg_wr && (paddr == REG_CAP_ADDR);

    // saturate the capacity at BOX_BYTES, the box size without slack; follow the incoming
    // value during a capacity write so the box clear loads the new size
    assign cap_eff = (32'(cap_next) > BOX_BYTES) ? AW'(BOX_BYTES) : AW'(cap_next);

    always_comb begin
        cap_next  = cap_reg;
        mask_next = mask_reg;
        if (cfg_wr) begin
            case (paddr)
                REG_CAP_ADDR:  cap_next  = pwdata[10:0];
                REG_MASK_ADDR: mask_next = pwdata[7:0];
                default: ;
            endcase
        end
        case (paddr)
            REG_CAP_ADDR:  prdata = {21'd0, cap_reg};
            REG_MASK_ADDR: prdata = {24'd0, mask_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= CAP_RESET;
            mask_reg <= MASK_RESET;
        end else begin
            cap_reg  <= cap_next;
            mask_reg <= mask_next;
        end
    end

    // classify and queue incoming transactions
    lpmr_front #(
        .NUM_BOXES (NUM_BOXES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_func      (s_tdata[2:0]),
        .s_box       (s_tdata[5:3]),
        .s_data_byte (s_tdata[13:6]),
        .enable_mask (mask_reg),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop)
    );

    // carry out operations against the rings and the store
    lpmr_back #(
        .NUM_BOXES   (NUM_BOXES),
        .BOX_BYTES   (BOX_BYTES),
        .SLACK_BYTES (SLACK_BYTES),
        .AW          (AW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cap_eff     (cap_eff),
        .cfg_clear   (cfg_clear),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_status    (r_status),
        .m_read_byte (r_byte),
        .m_eom       (m_tlast),
        .m_count     (r_count)
    );

    assign m_tdata = {4'd0, r_count, r_byte, r_status};

endmodule
